// File: src/fat12_pkg.sv
// shared constants and codes for the fat12 cluster chain walker
package fat12_pkg;

    localparam int TABLE_BYTES_DEF = 6144;
    localparam int MAX_RUN_DEF     = 64;

    localparam logic [11:0] END_MARK   = 12'hFF8;
    localparam logic [11:0] FIRST_DATA = 12'd2;
    localparam int          ODD_SHIFT  = 4;

    localparam logic [15:0] DATA_START_RESET = 16'd33;
    localparam logic [7:0]  SPC_RESET        = 8'd1;

    // configuration register indexes
    localparam logic CFG_DATA_START = 1'b0;
    localparam logic CFG_SPC        = 1'b1;

    // item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_WALK  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_LOW    = 2'd1,
        ST_TRUNC  = 2'd2,
        ST_BEYOND = 2'd3
    } status_t;

endpackage

// File: src/fat12_cluster_chain_walker.sv
// fat12 allocation table store and cluster chain walker, top level
// operation: a table write item completes at its accept edge; a walk item visits each
//   cluster in a read state (table read in bank memories) and then a decode state that
//   loads one result item, waiting there while the result register is stalled
// throughput: one item at a time, a new item is taken once the walk has ended
// reset: control state and configuration registers reset; table contents undefined until written
module fat12_cluster_chain_walker #(
    parameter int TABLE_BYTES = fat12_pkg::TABLE_BYTES_DEF,
    parameter int MAX_RUN     = fat12_pkg::MAX_RUN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [12:0] table_address,
    input  logic [7:0]  table_byte,
    input  logic [11:0] start_cluster,
    // result item channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] cluster_number,
    output logic [19:0] first_sector,
    output logic [5:0]  chain_position,
    output logic        last,
    output logic [1:0]  status,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    // the table is split into an even-byte bank and an odd-byte bank so that
    // the two bytes of one fat entry are fetched in the same cycle
    localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
    localparam int AW         = $clog2(BANK_DEPTH);
    localparam logic [13:0] TABLE_LIM = 14'(TABLE_BYTES);
    localparam logic [6:0]  RUN_LIM   = 7'(MAX_RUN);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_CALC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] even_mem [BANK_DEPTH];
    logic [7:0] odd_mem  [BANK_DEPTH];
    logic [7:0] even_q_reg;
    logic [7:0] odd_q_reg;

    logic [15:0] data_start_reg;
    logic [7:0]  spc_reg;

    logic [11:0] cur_reg, cur_next;
    logic [5:0]  pos_reg, pos_next;
    logic [19:0] prod_reg;

    logic        out_valid_reg, out_valid_next;
    logic [11:0] out_cluster_reg;
    logic [19:0] out_sector_reg;
    logic [5:0]  out_pos_reg;
    logic        out_last_reg;
    fat12_pkg::status_t out_status_reg;

    logic        in_fire;
    logic        out_free;
    logic        res_load;
    logic        wr_ok;
    logic [13:0] off;
    logic [13:0] off_plus;
    logic        beyond;
    logic        below_two;
    logic [12:0] odd_idx;
    logic [12:0] even_idx;
    logic        rd_en;
    logic [7:0]  lo_byte;
    logic [7:0]  hi_byte;
    logic [15:0] word;
    logic [11:0] next_clu;
    logic [19:0] sector;
    logic        run_full;
    logic        res_last;
    fat12_pkg::status_t res_status;
    logic [19:0] res_sector;

    // ---------------------------------------------------------------- handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg <= fat12_pkg::DATA_START_RESET;
            spc_reg        <= fat12_pkg::SPC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fat12_pkg::CFG_DATA_START: data_start_reg <= cfg_data;
                fat12_pkg::CFG_SPC:        spc_reg        <= cfg_data[7:0];
                default:                   ;
            endcase
        end
    end

    // ---------------------------------------------------------------- table store
    // a write item lands in the bank picked by the address lsb; out-of-range
    // addresses are dropped
    assign wr_ok = in_fire && (cmd == fat12_pkg::CMD_WRITE)
                   && ({1'b0, table_address} < TABLE_LIM);

    // byte offset of the entry: cluster * 3 / 2
    assign off       = ({2'b00, cur_reg} + {1'b0, cur_reg, 1'b0}) >> 1;
    assign off_plus  = off + 14'd1;
    assign beyond    = (off_plus >= TABLE_LIM);
    assign below_two = (cur_reg < fat12_pkg::FIRST_DATA);

    // even offset: low byte in even bank, high byte in odd bank at the same row
    // odd offset: low byte in odd bank, high byte in even bank one row up
    assign odd_idx  = off[13:1];
    assign even_idx = off[0] ? (off[13:1] + 13'd1) : off[13:1];
    assign rd_en    = (state_reg == S_READ) && !beyond && !below_two;

    always_ff @(posedge clk)
    begin
        if (wr_ok && !table_address[0])
        begin
            even_mem[table_address[AW:1]] <= table_byte;
        end
        if (wr_ok && table_address[0])
        begin
            odd_mem[table_address[AW:1]] <= table_byte;
        end
        if (rd_en)
        begin
            even_q_reg <= even_mem[even_idx[AW-1:0]];
            odd_q_reg  <= odd_mem[odd_idx[AW-1:0]];
        end
    end

    // ---------------------------------------------------------------- entry decode
    assign lo_byte  = off[0] ? odd_q_reg : even_q_reg;
    assign hi_byte  = off[0] ? even_q_reg : odd_q_reg;
    assign word     = {hi_byte, lo_byte};
    assign next_clu = cur_reg[0] ? 12'(word >> fat12_pkg::ODD_SHIFT) : word[11:0];
    assign sector   = {4'b0000, data_start_reg} + prod_reg;
    assign run_full = ({1'b0, pos_reg} + 7'd1) >= RUN_LIM;

    // result classification, in priority order
    always_comb
    begin
        res_last   = 1'b0;
        res_status = fat12_pkg::ST_OK;
        res_sector = sector;
        if (below_two)
        begin
            res_last   = 1'b1;
            res_status = fat12_pkg::ST_LOW;
            res_sector = '0;
        end
        else if (beyond)
        begin
            res_last   = 1'b1;
            res_status = fat12_pkg::ST_BEYOND;
            res_sector = '0;
        end
        else if (next_clu >= fat12_pkg::END_MARK)
        begin
            res_last = 1'b1;
        end
        else if (run_full)
        begin
            res_last   = 1'b1;
            res_status = fat12_pkg::ST_TRUNC;
        end
    end

    // ---------------------------------------------------------------- walk control
    assign res_load = (state_reg == S_CALC) && out_free;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        pos_next   = pos_reg;
        case (state_reg)
            S_IDLE:
            begin
                // a start at or past the end mark is an empty chain: no result
                if (in_fire && (cmd == fat12_pkg::CMD_WALK)
                    && (start_cluster < fat12_pkg::END_MARK))
                begin
                    cur_next   = start_cluster;
                    pos_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (res_load)
                begin
                    if (res_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next   = next_clu;
                        pos_next   = pos_reg + 6'd1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            pos_reg   <= pos_next;
        end
    end

    // sector offset product, registered ahead of the add
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            prod_reg <= {8'b0, cur_reg - fat12_pkg::FIRST_DATA} * {12'b0, spc_reg};
        end
    end

    // ---------------------------------------------------------------- result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_cluster_reg <= cur_reg;
            out_sector_reg  <= res_sector;
            out_pos_reg     <= pos_reg;
            out_last_reg    <= res_last;
            out_status_reg  <= res_status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cluster_number = out_cluster_reg;
    assign first_sector   = out_sector_reg;
    assign chain_position = out_pos_reg;
    assign last           = out_last_reg;
    assign status         = out_status_reg;

endmodule

// File: test/tb_top.sv
// self-checking testbench for the fat12 cluster chain walker
module tb_top;

    localparam int TABLE_BYTES   = fat12_pkg::TABLE_BYTES_DEF;
    localparam int MAX_RUN       = fat12_pkg::MAX_RUN_DEF;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 75;     // random items per configuration phase
    localparam int IDLE_PCT      = 9;      // idle and stall chance per cycle, percent
    localparam int QUIET_FROM    = 800;    // cycle window with no idling on either side
    localparam int QUIET_TO      = 1200;
    localparam int HOLD_AT       = 80;     // long result hold-off starts after this many items
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 10;     // covers a walk that ends with no result item
    localparam int POOL_SPAN     = 300;    // most chains live in a small cluster range
    localparam int LIMIT_CYCLES  = 600000;

    typedef struct {
        logic        op;
        logic [12:0] addr;
        logic [7:0]  data;
        logic [11:0] start;
    } fat_item_t;

    // one visited cluster as the walker should report it
    typedef struct {
        logic [11:0]        clu;
        logic [19:0]        sec;
        logic [5:0]         pos;
        logic               fin;
        fat12_pkg::status_t st;
    } visit_t;

    typedef struct {
        logic        idx;
        logic [15:0] data;
    } cfg_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = fat12_pkg::CMD_WRITE;
    logic [12:0] table_address = '0;
    logic [7:0]  table_byte = '0;
    logic [11:0] start_cluster = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] cluster_number;
    logic [19:0] first_sector;
    logic [5:0]  chain_position;
    logic        last;
    logic [1:0]  status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = fat12_pkg::CFG_DATA_START;
    logic [15:0] cfg_data = '0;

    fat12_cluster_chain_walker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .table_address  (table_address),
        .table_byte     (table_byte),
        .start_cluster  (start_cluster),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cluster_number (cluster_number),
        .first_sector   (first_sector),
        .chain_position (chain_position),
        .last           (last),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // item and config traffic between the stimulus block and the drivers
    fat_item_t  pending_items[$];
    cfg_write_t pending_cfg[$];
    visit_t     expected_visits[$];
    int         items_queued = 0;
    int         items_taken = 0;
    int         cfg_queued = 0;
    int         cfg_taken = 0;
    int         errors = 0;
    int         cyc = 0;
    logic       quiet;

    // predictor copy of the block state, updated at accept edges
    logic [7:0]  fat_bytes [TABLE_BYTES];
    logic [15:0] sector_base = fat12_pkg::DATA_START_RESET;
    logic [7:0]  cluster_sectors = fat12_pkg::SPC_RESET;

    // planning copy of the table, used only to keep walks on written bytes
    logic [7:0]  plan_bytes [TABLE_BYTES];
    bit          plan_written [TABLE_BYTES];
    logic [11:0] walked_starts[$];

    assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

    initial
    begin
        forever #10 clk = ~clk;
    end

    // follow a chain through the predictor table and queue one visit per cluster
    function automatic void predict_walk(logic [11:0] first);
        logic [11:0] cur;
        logic [11:0] nxt;
        logic [15:0] word;
        int          off;
        int          n;
        bit          done;
        visit_t      v;
        cur  = first;
        n    = 0;
        done = 1'b0;
        while (!done && cur < fat12_pkg::END_MARK && n < MAX_RUN)
        begin
            off   = int'(cur) * 3 / 2;
            v.clu = cur;
            v.pos = 6'(n);
            if (cur < fat12_pkg::FIRST_DATA)
            begin
                v.sec = '0;
                v.fin = 1'b1;
                v.st  = fat12_pkg::ST_LOW;
                done  = 1'b1;
            end
            else if (off + 1 >= TABLE_BYTES)
            begin
                v.sec = '0;
                v.fin = 1'b1;
                v.st  = fat12_pkg::ST_BEYOND;
                done  = 1'b1;
            end
            else
            begin
                // sector wraps to 20 bits
                v.sec = 20'(int'(sector_base) + (int'(cur) - 2) * int'(cluster_sectors));
                word  = {fat_bytes[off + 1], fat_bytes[off]};
                nxt   = cur[0] ? word[15:fat12_pkg::ODD_SHIFT] : word[11:0];
                v.fin = 1'b0;
                v.st  = fat12_pkg::ST_OK;
                if (nxt >= fat12_pkg::END_MARK)
                begin
                    v.fin = 1'b1;
                    done  = 1'b1;
                end
                else if (n + 1 >= MAX_RUN)
                begin
                    v.fin = 1'b1;
                    v.st  = fat12_pkg::ST_TRUNC;
                    done  = 1'b1;
                end
                else
                    cur = nxt;
            end
            expected_visits.push_back(v);
            n++;
        end
    endfunction

    function automatic void queue_item(logic op, logic [12:0] addr, logic [7:0] data,
                                       logic [11:0] first);
        fat_item_t it;
        it = '{op, addr, data, first};
        if (op == fat12_pkg::CMD_WRITE && addr < TABLE_BYTES)
        begin
            plan_bytes[addr]   = data;
            plan_written[addr] = 1'b1;
        end
        pending_items.push_back(it);
        items_queued++;
    endfunction

    // the walk fields of a write item carry random noise
    function automatic void queue_write(int addr, logic [7:0] data);
        queue_item(fat12_pkg::CMD_WRITE, 13'(addr), data, 12'($urandom));
    endfunction

    // write one 12-bit entry, keeping the neighbor's nibble if it is already set
    function automatic void set_entry(logic [11:0] clu, logic [11:0] link);
        int         off;
        logic [3:0] keep;
        off = int'(clu) * 3 / 2;
        if (!clu[0])
        begin
            keep = plan_written[off + 1] ? plan_bytes[off + 1][7:4] : 4'($urandom);
            queue_write(off, link[7:0]);
            queue_write(off + 1, {keep, link[11:8]});
        end
        else
        begin
            keep = plan_written[off] ? plan_bytes[off][3:0] : 4'($urandom);
            queue_write(off, {link[3:0], keep});
            queue_write(off + 1, link[11:4]);
        end
    endfunction

    function automatic logic [11:0] pick_cluster();
        if ($urandom_range(99) < 85)
            return 12'(2 + $urandom_range(POOL_SPAN));
        return 12'($urandom_range(12'hFF7, 2));
    endfunction

    // next-cluster value: end mark, reserved cluster, or another cluster
    function automatic logic [11:0] pick_link();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return fat12_pkg::END_MARK + 12'($urandom_range(7));
        if (r < 40)
            return 12'($urandom_range(1));
        return pick_cluster();
    endfunction

    // fill any unwritten entry the walk would read, then queue the walk
    function automatic void queue_walk(logic [11:0] first);
        logic [11:0] cur;
        logic [15:0] word;
        int          off;
        int          n;
        cur = first;
        n   = 0;
        while (cur >= fat12_pkg::FIRST_DATA && cur < fat12_pkg::END_MARK && n < MAX_RUN)
        begin
            off = int'(cur) * 3 / 2;
            if (off + 1 >= TABLE_BYTES)
                break;
            if (!plan_written[off] || !plan_written[off + 1])
                set_entry(cur, pick_link());
            word = {plan_bytes[off + 1], plan_bytes[off]};
            cur  = cur[0] ? word[15:fat12_pkg::ODD_SHIFT] : word[11:0];
            n++;
        end
        queue_item(fat12_pkg::CMD_WALK, 13'($urandom), 8'($urandom), first);
        walked_starts.push_back(first);
    endfunction

    // a fresh chain with random clusters, mostly ending on an end mark
    function automatic void build_chain();
        logic [11:0] head;
        logic [11:0] cur;
        logic [11:0] nxt;
        int          len;
        len  = ($urandom_range(99) < 4) ? $urandom_range(70, 40) : $urandom_range(10, 1);
        head = pick_cluster();
        cur  = head;
        for (int i = 1; i < len; i++)
        begin
            nxt = pick_cluster();
            set_entry(cur, nxt);
            cur = nxt;
        end
        if ($urandom_range(99) < 85)
            set_entry(cur, fat12_pkg::END_MARK + 12'($urandom_range(7)));
        else
            set_entry(cur, 12'($urandom_range(1)));
        queue_walk(head);
    endfunction

    function automatic void random_step();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            build_chain();
        else if (r < 65)
            queue_walk(pick_cluster());
        else if (r < 80)
            queue_walk(walked_starts[$urandom_range(walked_starts.size() - 1)]);
        else if (r < 90)
            queue_write($urandom_range(8191), 8'($urandom));
        else if (r < 95)
            queue_walk(($urandom_range(1) == 0)
                       ? 12'($urandom_range(1))
                       : fat12_pkg::END_MARK + 12'($urandom_range(7)));
        else
            set_entry(pick_cluster(), pick_link());
    endfunction

    function automatic void queue_config(logic [15:0] base, logic [7:0] spc);
        pending_cfg.push_back('{fat12_pkg::CFG_DATA_START, base});
        pending_cfg.push_back('{fat12_pkg::CFG_SPC, {8'd0, spc}});
        cfg_queued += 2;
    endfunction

    function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // wait for every item to be taken and every visit to arrive, then let the block settle
    task automatic drain();
        while (items_taken != items_queued || expected_visits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // item driver: predicts at the accept edge, then offers the next item
    always @(posedge clk or negedge rst_n)
    begin : item_driver
        fat_item_t nxt_item;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            cmd           <= fat12_pkg::CMD_WRITE;
            table_address <= '0;
            table_byte    <= '0;
            start_cluster <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (cmd == fat12_pkg::CMD_WRITE)
                begin
                    // writes past the table are dropped
                    if (table_address < TABLE_BYTES)
                        fat_bytes[table_address] = table_byte;
                end
                else
                    predict_walk(start_cluster);
                items_taken = items_taken + 1;
            end
            // a stalled item stays put, otherwise offer the next one or idle
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt_item      = pending_items.pop_front();
                    in_valid      <= 1'b1;
                    cmd           <= nxt_item.op;
                    table_address <= nxt_item.addr;
                    table_byte    <= nxt_item.data;
                    start_cluster <= nxt_item.start;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // config driver: the predictor takes each register value at its write edge
    always @(posedge clk or negedge rst_n)
    begin : cfg_driver
        cfg_write_t w;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= fat12_pkg::CFG_DATA_START;
            cfg_data  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fat12_pkg::CFG_DATA_START)
                    sector_base = cfg_data;
                else
                    cluster_sectors = cfg_data[7:0];
                cfg_taken = cfg_taken + 1;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (pending_cfg.size() > 0)
                begin
                    w         = pending_cfg.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.idx;
                    cfg_data  <= w.data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall, with one long hold-off that backs up the input
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        visit_t v;
        int     hold_left;
        bit     hold_done;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            cyc       <= 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_visits.size() == 0)
                begin
                    $error("result item with no expectation: cluster_number %0h",
                           cluster_number);
                    errors++;
                end
                else
                begin
                    v = expected_visits.pop_front();
                    check_field("cluster_number", 20'(v.clu), 20'(cluster_number));
                    check_field("first_sector", v.sec, first_sector);
                    check_field("chain_position", 20'(v.pos), 20'(chain_position));
                    check_field("last", 20'(v.fin), 20'(last));
                    check_field("status", 20'(v.st), 20'(status));
                end
            end
            if (!hold_done && items_taken >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin : stimulus
        int phase_end;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset configuration
        queue_write(8191, 8'hFF);          // past the table, ignored
        queue_write(TABLE_BYTES - 1, 8'h00);
        queue_walk(12'd0);                 // reserved clusters flag at once
        queue_walk(12'd1);
        queue_walk(12'hFFF);               // empty chain, no result item
        set_entry(12'd2, 12'd2);           // self loop runs into the run limit
        queue_walk(12'd2);
        set_entry(12'd3, fat12_pkg::END_MARK);  // single cluster, lowest end mark
        queue_walk(12'd3);
        set_entry(12'd4, 12'd5);           // even then odd entry
        set_entry(12'd5, 12'hFFF);
        queue_walk(12'd4);
        set_entry(12'd6, 12'd1);           // chain into a reserved cluster
        queue_walk(12'd6);
        set_entry(12'd8, 12'hFF7);         // highest data cluster
        set_entry(12'hFF7, 12'hFFF);
        queue_walk(12'd8);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: queue_config(16'd0, 8'd0);
                1: queue_config(16'hFFFF, 8'd128);
                2: queue_config(16'hFFFF, 8'hFF);     // sector field wraps
                3: queue_config(16'($urandom), 8'($urandom_range(128, 1)));
                default: queue_config(16'd0, 8'd1);
            endcase
            while (cfg_taken != cfg_queued)
                @(posedge clk);
            queue_walk(12'hFF7);
            phase_end = items_queued + PHASE_ITEMS;
            while (items_queued < phase_end)
                random_step();
            drain();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #(20 * LIMIT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: fat12_cluster_chain_walker.f
src/fat12_pkg.sv
src/fat12_cluster_chain_walker.sv
test/tb_top.sv
